// ----- src/ddec_pkg.sv -----
// ddec_pkg: widths, class codes and the month table for the date difference block
// no dependencies; used by every module of the block
`default_nettype none

package ddec_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int WARN_W   = 10;
   localparam int SERIAL_W = 24;
   localparam int DIFF_W   = 25;
   localparam int OUT_W    = 23;
   localparam int CUM_W    = 9;
   localparam int BASE_W   = 23;

   localparam logic [WARN_W-1:0] WARN_RESET = WARN_W'(3);

   // floor(x * DIV100_MUL / 2**DIV100_SHIFT) == floor(x / 100) for x < 43699
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int MUL_W        = YEAR_W + 13;

   localparam int DAYS_PER_YEAR = 365;
   localparam int MONTH_LAST    = 12;

   typedef enum logic [1:0] {
      CLASS_BEYOND  = 2'd0,
      CLASS_NEAR    = 2'd1,
      CLASS_TODAY   = 2'd2,
      CLASS_EXPIRED = 2'd3
   } expiry_class_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   // days of the whole months before month index idx (0 is January)
   function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] idx);
      logic [CUM_W-1:0] r;
      case (idx)
         4'd0:    r = CUM_W'(0);
         4'd1:    r = CUM_W'(31);
         4'd2:    r = CUM_W'(59);
         4'd3:    r = CUM_W'(90);
         4'd4:    r = CUM_W'(120);
         4'd5:    r = CUM_W'(151);
         4'd6:    r = CUM_W'(181);
         4'd7:    r = CUM_W'(212);
         4'd8:    r = CUM_W'(243);
         4'd9:    r = CUM_W'(273);
         4'd10:   r = CUM_W'(304);
         4'd11:   r = CUM_W'(334);
         default: r = CUM_W'(365);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/ddec_serial.sv -----
// ddec_serial: turns one date into its serial day number, combinational
// depends on ddec_pkg
`default_nettype none

module ddec_serial
   import ddec_pkg::*;
(
   input  wire date_type             date,
   output logic signed [SERIAL_W-1:0] serial
);

   logic [YEAR_W-1:0]  prev_year;
   logic               year_zero;
   logic [MUL_W-1:0]   prod_prev;
   logic [MUL_W-1:0]   prod_year;
   logic [YEAR_W-1:0]  q100_prev;
   logic [YEAR_W-1:0]  q100_year;
   logic [YEAR_W-1:0]  q400_prev;
   logic [YEAR_W-1:0]  q400_year;
   logic [BASE_W-1:0]  base;
   logic               leap;
   logic [MONTH_W-1:0] month_idx;
   logic [CUM_W-1:0]   month_days;
   logic               leap_add;

   always_comb begin
      year_zero = (date.year == '0);
      prev_year = date.year - YEAR_W'(1);

      // constant reciprocal divide by 100, then by 4 more for 400
      prod_prev = MUL_W'(prev_year) * MUL_W'(DIV100_MUL);
      prod_year = MUL_W'(date.year) * MUL_W'(DIV100_MUL);
      q100_prev = YEAR_W'(prod_prev >> DIV100_SHIFT);
      q100_year = YEAR_W'(prod_year >> DIV100_SHIFT);
      q400_prev = q100_prev >> 2;
      q400_year = q100_year >> 2;

      base = BASE_W'(prev_year) * BASE_W'(DAYS_PER_YEAR)
           + BASE_W'(prev_year >> 2)
           - BASE_W'(q100_prev)
           + BASE_W'(q400_prev);

      // a century boundary falls between prev_year and year exactly when year is a multiple of 100
      if (year_zero) begin
         leap = 1'b1;
      end else begin
         leap = ((date.year[1:0] == 2'b00) && (q100_year == q100_prev))
              || (q400_year != q400_prev);
      end

      if (date.month == '0) begin
         month_idx = '0;
      end else if (date.month > MONTH_W'(MONTH_LAST)) begin
         month_idx = MONTH_W'(MONTH_LAST);
      end else begin
         month_idx = date.month - MONTH_W'(1);
      end
      month_days = cum_days(month_idx);
      leap_add   = leap && (month_idx >= MONTH_W'(2));

      if (year_zero) begin
         serial = -SERIAL_W'(DAYS_PER_YEAR);
      end else begin
         serial = $signed(SERIAL_W'(base));
      end
      serial = serial + $signed(SERIAL_W'(month_days)) + $signed(SERIAL_W'(leap_add))
             + $signed(SERIAL_W'(date.day));
   end

endmodule

`default_nettype wire

// ----- src/ddec_classify.sv -----
// ddec_classify: difference of two serial numbers, saturation and expiry class
// depends on ddec_pkg
`default_nettype none

module ddec_classify
   import ddec_pkg::*;
(
   input  wire logic signed [SERIAL_W-1:0] start_serial,
   input  wire logic signed [SERIAL_W-1:0] end_serial,
   input  wire logic [WARN_W-1:0]          warn_days,
   output logic [OUT_W-1:0]                day_difference,
   output expiry_class_type                expiry_class
);

   logic signed [DIFF_W-1:0] diff;
   logic                     fits;

   always_comb begin
      diff = DIFF_W'(end_serial) - DIFF_W'(start_serial);

      // fits when the bits above the output sign all match it
      fits = (diff[DIFF_W-1:OUT_W-1] == '0) || (diff[DIFF_W-1:OUT_W-1] == '1);
      if (fits) begin
         day_difference = diff[OUT_W-1:0];
      end else if (diff[DIFF_W-1]) begin
         day_difference = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         day_difference = {1'b0, {(OUT_W-1){1'b1}}};
      end

      if (diff[DIFF_W-1]) begin
         expiry_class = CLASS_EXPIRED;
      end else if (diff == '0) begin
         expiry_class = CLASS_TODAY;
      end else if (diff <= $signed(DIFF_W'(warn_days))) begin
         expiry_class = CLASS_NEAR;
      end else begin
         expiry_class = CLASS_BEYOND;
      end
   end

endmodule

`default_nettype wire

// ----- src/date_difference_expiry_class.sv -----
// date_difference_expiry_class: top level, input register, day numbers, result register
// depends on ddec_pkg, ddec_serial and ddec_classify
// Accepts one date pair in every clock cycle (busy is always low); the result appears on
// the rsp_ ports with rsp_strobe after the input register and the result register, held
// for one cycle, and the receiver cannot stall it. Both serial day numbers, the difference
// and the class are computed combinationally between the input and result registers.
// csr_warn_days is always ready and should be written only while no item is in flight.
`default_nettype none

module date_difference_expiry_class
   import ddec_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [YEAR_W-1:0]  req_start_year,
   input  wire logic [MONTH_W-1:0] req_start_month,
   input  wire logic [DAY_W-1:0]   req_start_day,
   input  wire logic [YEAR_W-1:0]  req_end_year,
   input  wire logic [MONTH_W-1:0] req_end_month,
   input  wire logic [DAY_W-1:0]   req_end_day,
   output logic                    rsp_strobe,
   output logic [OUT_W-1:0]        rsp_day_difference,
   output logic [1:0]              rsp_expiry_class,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [WARN_W-1:0]  csr_warn_days
);

   logic                          item_valid_ff;
   date_type                      start_date_ff;
   date_type                      end_date_ff;
   logic [WARN_W-1:0]             warn_ff;
   logic                          rsp_strobe_ff;
   logic [OUT_W-1:0]              diff_ff;
   expiry_class_type              class_ff;

   logic                          accept;
   logic signed [SERIAL_W-1:0]    start_serial;
   logic signed [SERIAL_W-1:0]    end_serial;
   logic [OUT_W-1:0]              diff_in;
   expiry_class_type              class_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         warn_ff       <= WARN_RESET;
      end else begin
         item_valid_ff <= accept;
         rsp_strobe_ff <= item_valid_ff;
         if (csr_valid && csr_ready) begin
            warn_ff <= csr_warn_days;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         start_date_ff <= '{year: req_start_year, month: req_start_month, day: req_start_day};
         end_date_ff   <= '{year: req_end_year, month: req_end_month, day: req_end_day};
      end
      if (item_valid_ff) begin
         diff_ff  <= diff_in;
         class_ff <= class_in;
      end
   end

   ddec_serial u_start_serial (
      .date   (start_date_ff),
      .serial (start_serial)
   );

   ddec_serial u_end_serial (
      .date   (end_date_ff),
      .serial (end_serial)
   );

   ddec_classify u_classify (
      .start_serial   (start_serial),
      .end_serial     (end_serial),
      .warn_days      (warn_ff),
      .day_difference (diff_in),
      .expiry_class   (class_in)
   );

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_day_difference = diff_ff;
   assign rsp_expiry_class   = class_ff;

`ifndef SYNTHESIS
   a_stage_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> item_valid_ff)
      else $error("input stage did not capture accepted item");

   a_strobe_two_after: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("result strobe missing two cycles after accept");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(item_valid_ff))
      else $error("result strobe without an item in the input stage");

   a_today_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && class_ff == CLASS_TODAY) |-> (rsp_day_difference == '0))
      else $error("today class with nonzero difference");

   a_expired_neg: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && class_ff == CLASS_EXPIRED) |-> rsp_day_difference[OUT_W-1])
      else $error("expired class with nonnegative difference");
`endif

endmodule

`default_nettype wire
